// ----- hw/rtl/aluf_pkg.sv -----
// shared types and constants of the alu with status flags
// no dependencies

package aluf_pkg;

   localparam int unsigned DataWidth = 32;
   localparam int unsigned CmdWidth  = 4;
   localparam int unsigned DivCells  = DataWidth;

   typedef enum logic [CmdWidth-1:0] {
      CMD_ADD  = 4'd0,
      CMD_SUB  = 4'd1,
      CMD_MUL  = 4'd2,
      CMD_UDIV = 4'd3,
      CMD_SDIV = 4'd4,
      CMD_AND  = 4'd5,
      CMD_OR   = 4'd6,
      CMD_XOR  = 4'd7,
      CMD_NOT  = 4'd8,
      CMD_SHL  = 4'd9,
      CMD_SHR  = 4'd10,
      CMD_CMP  = 4'd11,
      CMD_TST  = 4'd12
   } cmd_type;

   // one word in flight; for mul the product rides in rem (high) and quo (low)
   typedef struct packed {
      logic                 valid;
      logic [CmdWidth-1:0]  cmd;
      logic                 is_div;
      logic                 negate;
      logic [DataWidth-1:0] divisor;
      logic [DataWidth-1:0] rem;
      logic [DataWidth-1:0] quo;
      logic [DataWidth-1:0] res;
      logic                 wb;
      logic                 fu;
      logic                 carry;
      logic                 ovf;
      logic                 derr;
   } item_type;

endpackage

// ----- hw/rtl/alu_with_status_flags_top.sv -----
// top level of the 32-bit alu with zero, sign, carry and overflow flags
// depends on aluf_pkg, aluf_front, aluf_div_cell, aluf_back
//
// usage
//   a word is taken at a rising edge where start is high and busy is low;
//   req_cmd selects add, sub, mul, udiv, sdiv, and, or, xor, not, shl, shr,
//   cmp or tst on req_dest_value and req_source_value
//   every word gives one result word, shown for exactly one cycle with
//   rsp_strobe high; the receiver cannot stall, so nothing is held back
// timing
//   one front stage (decode, add, sub, logic and shift ops, 32x32 multiplier,
//   operand magnitudes), a chain of 32 divider cells that each settle one
//   quotient bit, and one output stage that fixes the quotient sign and the
//   flags; every operation walks the same chain so results stay in order
//   throughput is one word per cycle, busy is low outside of reset
// reset
//   synchronous, active high; clears the valid bits of all stages, so no
//   result word comes out of words that were in flight; busy is high while
//   reset is asserted

module alu_with_status_flags_top (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   output logic                           busy,
   input  logic [aluf_pkg::CmdWidth-1:0]  req_cmd,
   input  logic [aluf_pkg::DataWidth-1:0] req_dest_value,
   input  logic [aluf_pkg::DataWidth-1:0] req_source_value,
   output logic                           rsp_strobe,
   output logic [aluf_pkg::DataWidth-1:0] rsp_result_value,
   output logic                           rsp_write_back,
   output logic                           rsp_flags_update,
   output logic                           rsp_zero_flag,
   output logic                           rsp_sign_flag,
   output logic                           rsp_carry_flag,
   output logic                           rsp_overflow_flag,
   output logic                           rsp_divide_error
);

   // stage[0] is the front register, stage[k+1] the output of divider cell k
   aluf_pkg::item_type stage [0:aluf_pkg::DivCells];

   // the pipeline never backs up, so only reset holds off new words
   assign busy = reset;

   aluf_front u_front (
      .clock        (clock),
      .reset        (reset),
      .accept       (start && !busy),
      .cmd          (req_cmd),
      .dest_value   (req_dest_value),
      .source_value (req_source_value),
      .item_out     (stage[0])
   );

   // divider chain; non-divide words ride along untouched
   for (genvar k = 0; k < aluf_pkg::DivCells; k++) begin : g_cell
      aluf_div_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .item_in  (stage[k]),
         .item_out (stage[k+1])
      );
   end

   aluf_back u_back (
      .clock         (clock),
      .reset         (reset),
      .item_in       (stage[aluf_pkg::DivCells]),
      .strobe        (rsp_strobe),
      .result_value  (rsp_result_value),
      .write_back    (rsp_write_back),
      .flags_update  (rsp_flags_update),
      .zero_flag     (rsp_zero_flag),
      .sign_flag     (rsp_sign_flag),
      .carry_flag    (rsp_carry_flag),
      .overflow_flag (rsp_overflow_flag),
      .divide_error  (rsp_divide_error)
   );

endmodule

// ----- hw/rtl/aluf_front.sv -----
// first stage: decode, add, sub, logic and shift ops, multiplier and divider setup
// depends on aluf_pkg

module aluf_front (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          accept,
   input  logic [aluf_pkg::CmdWidth-1:0]  cmd,
   input  logic [aluf_pkg::DataWidth-1:0] dest_value,
   input  logic [aluf_pkg::DataWidth-1:0] source_value,
   output aluf_pkg::item_type            item_out
);

   aluf_pkg::item_type item_in;
   aluf_pkg::item_type item_ff;
   logic [aluf_pkg::DataWidth:0]     sum;
   logic [aluf_pkg::DataWidth-1:0]   diff;
   logic [2*aluf_pkg::DataWidth-1:0] prod;
   logic [aluf_pkg::DataWidth:0]     shl_val;
   logic [aluf_pkg::DataWidth:0]     shr_val;
   logic [4:0]                       shamt;
   logic [aluf_pkg::DataWidth-1:0]   mag_a;
   logic [aluf_pkg::DataWidth-1:0]   mag_b;

   always_comb begin
      sum     = {1'b0, dest_value} + {1'b0, source_value};
      diff    = dest_value - source_value;
      prod    = {{aluf_pkg::DataWidth{1'b0}}, dest_value} *
                {{aluf_pkg::DataWidth{1'b0}}, source_value};
      shamt   = source_value[4:0];
      shl_val = {1'b0, dest_value} << shamt;
      shr_val = {dest_value, 1'b0} >> shamt;
      mag_a   = dest_value[aluf_pkg::DataWidth-1] ? (~dest_value + 1'b1) : dest_value;
      mag_b   = source_value[aluf_pkg::DataWidth-1] ? (~source_value + 1'b1) : source_value;

      item_in         = '0;
      item_in.valid   = accept;
      item_in.cmd     = cmd;
      item_in.wb      = 1'b1;
      item_in.fu      = 1'b1;
      unique case (cmd)
         aluf_pkg::CMD_ADD: begin
            item_in.res   = sum[aluf_pkg::DataWidth-1:0];
            item_in.carry = sum[aluf_pkg::DataWidth];
            item_in.ovf   = ~(dest_value[31] ^ source_value[31]) & (dest_value[31] ^ sum[31]);
         end
         aluf_pkg::CMD_SUB, aluf_pkg::CMD_CMP: begin
            item_in.res   = diff;
            item_in.carry = dest_value >= source_value;
            item_in.ovf   = (dest_value[31] ^ source_value[31]) & (dest_value[31] ^ diff[31]);
            item_in.wb    = cmd != aluf_pkg::CMD_CMP;
         end
         aluf_pkg::CMD_MUL: begin
            item_in.rem = prod[2*aluf_pkg::DataWidth-1:aluf_pkg::DataWidth];
            item_in.quo = prod[aluf_pkg::DataWidth-1:0];
         end
         aluf_pkg::CMD_UDIV, aluf_pkg::CMD_SDIV: begin
            if (source_value == '0) begin
               item_in.derr = 1'b1;
               item_in.wb   = 1'b0;
               item_in.fu   = 1'b0;
            end else if (cmd == aluf_pkg::CMD_SDIV) begin
               item_in.is_div  = 1'b1;
               item_in.negate  = dest_value[31] ^ source_value[31];
               item_in.divisor = mag_b;
               item_in.quo     = mag_a;
            end else begin
               item_in.is_div  = 1'b1;
               item_in.divisor = source_value;
               item_in.quo     = dest_value;
            end
         end
         aluf_pkg::CMD_AND, aluf_pkg::CMD_TST: begin
            item_in.res = dest_value & source_value;
            item_in.wb  = cmd != aluf_pkg::CMD_TST;
         end
         aluf_pkg::CMD_OR:  item_in.res = dest_value | source_value;
         aluf_pkg::CMD_XOR: item_in.res = dest_value ^ source_value;
         aluf_pkg::CMD_NOT: item_in.res = ~dest_value;
         aluf_pkg::CMD_SHL: begin
            item_in.res   = shl_val[aluf_pkg::DataWidth-1:0];
            item_in.carry = shl_val[aluf_pkg::DataWidth];
         end
         aluf_pkg::CMD_SHR: begin
            item_in.res   = shr_val[aluf_pkg::DataWidth:1];
            item_in.carry = shr_val[0];
         end
         default: begin
            item_in.wb = 1'b0;
            item_in.fu = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         item_ff <= '0;
      end else begin
         item_ff <= item_in;
      end
   end

   assign item_out = item_ff;

endmodule

// ----- hw/rtl/aluf_div_cell.sv -----
// one restoring divider cell: one quotient bit per cell, word passed on
// depends on aluf_pkg

module aluf_div_cell (
   input  logic               clock,
   input  logic               reset,
   input  aluf_pkg::item_type item_in,
   output aluf_pkg::item_type item_out
);

   aluf_pkg::item_type item_next;
   aluf_pkg::item_type item_ff;
   logic [aluf_pkg::DataWidth+1:0] trial;

   always_comb begin
      item_next = item_in;
      trial = {1'b0, item_in.rem, item_in.quo[aluf_pkg::DataWidth-1]} -
              {2'b00, item_in.divisor};
      if (item_in.is_div) begin
         if (!trial[aluf_pkg::DataWidth+1]) begin
            item_next.rem = trial[aluf_pkg::DataWidth-1:0];
            item_next.quo = {item_in.quo[aluf_pkg::DataWidth-2:0], 1'b1};
         end else begin
            item_next.rem = {item_in.rem[aluf_pkg::DataWidth-2:0],
                             item_in.quo[aluf_pkg::DataWidth-1]};
            item_next.quo = {item_in.quo[aluf_pkg::DataWidth-2:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         item_ff <= '0;
      end else begin
         item_ff <= item_next;
      end
   end

   assign item_out = item_ff;

endmodule

// ----- hw/rtl/aluf_back.sv -----
// last stage: quotient sign fix, product fold-in with its carry, zero and sign flags
// depends on aluf_pkg

module aluf_back (
   input  logic                           clock,
   input  logic                           reset,
   input  aluf_pkg::item_type             item_in,
   output logic                           strobe,
   output logic [aluf_pkg::DataWidth-1:0] result_value,
   output logic                           write_back,
   output logic                           flags_update,
   output logic                           zero_flag,
   output logic                           sign_flag,
   output logic                           carry_flag,
   output logic                           overflow_flag,
   output logic                           divide_error
);

   logic [aluf_pkg::DataWidth-1:0] res_in;
   logic                           zero_in;
   logic                           carry_in;
   logic                           strobe_ff;
   logic [aluf_pkg::DataWidth-1:0] res_ff;
   logic [6:0]                     bits_ff;

   always_comb begin
      res_in   = item_in.res;
      carry_in = item_in.carry;
      zero_in  = item_in.fu & (item_in.res == '0);
      if (item_in.is_div) begin
         res_in  = item_in.negate ? (~item_in.quo + 1'b1) : item_in.quo;
         zero_in = res_in == '0;
      end else if (item_in.cmd == aluf_pkg::CMD_MUL) begin
         res_in   = item_in.quo;
         carry_in = item_in.rem != '0;
         zero_in  = (item_in.rem == '0) && (item_in.quo == '0);
      end else if (item_in.cmd == aluf_pkg::CMD_ADD) begin
         zero_in = (item_in.res == '0) && !item_in.carry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         strobe_ff <= 1'b0;
      end else begin
         strobe_ff <= item_in.valid;
      end
   end

   always_ff @(posedge clock) begin
      res_ff  <= res_in;
      bits_ff <= {item_in.wb, item_in.fu, zero_in, carry_in, item_in.ovf,
                  item_in.derr, res_in[aluf_pkg::DataWidth-1]};
   end

   assign strobe        = strobe_ff;
   assign result_value  = res_ff;
   assign write_back    = bits_ff[6];
   assign flags_update  = bits_ff[5];
   assign zero_flag     = bits_ff[4];
   assign carry_flag    = bits_ff[3];
   assign overflow_flag = bits_ff[2];
   assign divide_error  = bits_ff[1];
   assign sign_flag     = bits_ff[0];

endmodule

// ----- hw/rtl/aluf_checker.sv -----
// port-level checks of the alu with status flags, bound to the top level
// depends on alu_with_status_flags_top

module aluf_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_strobe,
   input logic [31:0] rsp_result_value,
   input logic        rsp_write_back,
   input logic        rsp_flags_update,
   input logic        rsp_zero_flag,
   input logic        rsp_carry_flag,
   input logic        rsp_overflow_flag,
   input logic        rsp_divide_error
);

   // no result word right after a reset edge
   a_quiet_after_reset: assert property (@(posedge clock)
      $past(reset) |-> !rsp_strobe) else $error("result word after reset");

   a_derr_no_update: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_divide_error) |-> (!rsp_write_back && !rsp_flags_update))
      else $error("divide error with write-back or flag update");

   a_wb_needs_flags: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_write_back) |-> rsp_flags_update)
      else $error("write-back without flag update");

   a_no_update_clear: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && !rsp_flags_update) |->
      (rsp_result_value == 32'd0 && !rsp_zero_flag && !rsp_carry_flag && !rsp_overflow_flag))
      else $error("dropped word carries data");

endmodule

bind alu_with_status_flags_top aluf_checker u_aluf_checker (
   .clock             (clock),
   .reset             (reset),
   .rsp_strobe        (rsp_strobe),
   .rsp_result_value  (rsp_result_value),
   .rsp_write_back    (rsp_write_back),
   .rsp_flags_update  (rsp_flags_update),
   .rsp_zero_flag     (rsp_zero_flag),
   .rsp_carry_flag    (rsp_carry_flag),
   .rsp_overflow_flag (rsp_overflow_flag),
   .rsp_divide_error  (rsp_divide_error)
);

// ----- tb/sv/testbench.sv -----
`timescale 1ns / 1ps
// self-checking testbench of alu_with_status_flags_top
// depends on aluf_pkg and the rtl of the alu; drives directed and random words

module testbench;

   typedef struct packed {
      logic [31:0] result_value;
      logic        write_back;
      logic        flags_update;
      logic        zero_flag;
      logic        sign_flag;
      logic        carry_flag;
      logic        overflow_flag;
      logic        divide_error;
   } alu_out_type;

   typedef struct {
      logic [3:0]  cmd;
      logic [31:0] dest_value;
      logic [31:0] source_value;
      logic        has_golden;   // expected word typed in by hand
      alu_out_type golden;
   } stim_row_type;

   localparam int WatchdogLimit = 2000;
   localparam int DrainCycles   = 60;
   localparam int RandomWords   = 1500;

   logic        clock;
   logic        reset;
   logic        start;
   logic        busy;
   logic [3:0]  req_cmd;
   logic [31:0] req_dest_value;
   logic [31:0] req_source_value;
   logic        rsp_strobe;
   logic [31:0] rsp_result_value;
   logic        rsp_write_back;
   logic        rsp_flags_update;
   logic        rsp_zero_flag;
   logic        rsp_sign_flag;
   logic        rsp_carry_flag;
   logic        rsp_overflow_flag;
   logic        rsp_divide_error;

   alu_out_type pending_results[$];
   int       error_count;
   int       words_sent;
   int       words_checked;
   int       idle_cycles;
   int       op_seen[16];

   alu_with_status_flags_top dut (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_cmd           (req_cmd),
      .req_dest_value    (req_dest_value),
      .req_source_value  (req_source_value),
      .rsp_strobe        (rsp_strobe),
      .rsp_result_value  (rsp_result_value),
      .rsp_write_back    (rsp_write_back),
      .rsp_flags_update  (rsp_flags_update),
      .rsp_zero_flag     (rsp_zero_flag),
      .rsp_sign_flag     (rsp_sign_flag),
      .rsp_carry_flag    (rsp_carry_flag),
      .rsp_overflow_flag (rsp_overflow_flag),
      .rsp_divide_error  (rsp_divide_error)
   );

   // 8 ns clock
   always begin
      clock = 1'b1;
      #4;
      clock = 1'b0;
      #4;
   end

   // predicts the alu output for one command word
   function automatic alu_out_type compute_alu(logic [3:0] cmd, logic [31:0] a,
                                               logic [31:0] b);
      alu_out_type r;
      logic [63:0] wide;
      logic [31:0] ma;
      logic [31:0] mb;
      logic [31:0] q;
      logic        use_wide;
      int unsigned n;
      r        = '0;
      r.write_back   = 1'b1;
      r.flags_update = 1'b1;
      use_wide = 1'b0;
      wide     = '0;
      n        = b[4:0];
      case (cmd)
         aluf_pkg::CMD_ADD: begin
            wide = {32'd0, a} + {32'd0, b};
            r.result_value  = wide[31:0];
            use_wide        = 1'b1;
            r.carry_flag    = wide[32];
            r.overflow_flag = ~(a[31] ^ b[31]) & (a[31] ^ wide[31]);
         end
         aluf_pkg::CMD_SUB, aluf_pkg::CMD_CMP: begin
            r.result_value  = a - b;
            r.carry_flag    = (a >= b);
            r.overflow_flag = (a[31] ^ b[31]) & (a[31] ^ r.result_value[31]);
            if (cmd == aluf_pkg::CMD_CMP) r.write_back = 1'b0;
         end
         aluf_pkg::CMD_MUL: begin
            wide = {32'd0, a} * {32'd0, b};
            r.result_value = wide[31:0];
            use_wide       = 1'b1;
            r.carry_flag   = (wide[63:32] != 0);
         end
         aluf_pkg::CMD_UDIV, aluf_pkg::CMD_SDIV: begin
            if (b == 0) begin
               r.divide_error = 1'b1;
               r.write_back   = 1'b0;
               r.flags_update = 1'b0;
            end else if (cmd == aluf_pkg::CMD_UDIV) begin
               r.result_value = a / b;
            end else begin
               // magnitudes, truncate toward zero, then restore sign
               ma = a[31] ? -a : a;
               mb = b[31] ? -b : b;
               q  = ma / mb;
               r.result_value = (a[31] ^ b[31]) ? -q : q;
            end
         end
         aluf_pkg::CMD_AND, aluf_pkg::CMD_TST: begin
            r.result_value = a & b;
            if (cmd == aluf_pkg::CMD_TST) r.write_back = 1'b0;
         end
         aluf_pkg::CMD_OR:  r.result_value = a | b;
         aluf_pkg::CMD_XOR: r.result_value = a ^ b;
         aluf_pkg::CMD_NOT: r.result_value = ~a;
         aluf_pkg::CMD_SHL: begin
            r.result_value = a << n;
            if (n > 0) r.carry_flag = a[32 - n];
         end
         aluf_pkg::CMD_SHR: begin
            r.result_value = a >> n;
            if (n > 0) r.carry_flag = a[n - 1];
         end
         default: begin
            // unused codes: a word of zeros
            r.write_back   = 1'b0;
            r.flags_update = 1'b0;
         end
      endcase
      if (r.flags_update) begin
         r.zero_flag = use_wide ? (wide == 0) : (r.result_value == 0);
      end else begin
         r.result_value  = '0;
         r.carry_flag    = 1'b0;
         r.overflow_flag = 1'b0;
      end
      r.sign_flag = r.result_value[31];
      return r;
   endfunction

   function automatic stim_row_type mk_row(logic [3:0] cmd, logic [31:0] a, logic [31:0] b);
      stim_row_type s;
      s.cmd          = cmd;
      s.dest_value   = a;
      s.source_value = b;
      s.has_golden   = 1'b0;
      s.golden       = '0;
      return s;
   endfunction

   function automatic stim_row_type mk_gold(logic [3:0] cmd, logic [31:0] a, logic [31:0] b,
                                            alu_out_type g);
      stim_row_type s;
      s            = mk_row(cmd, a, b);
      s.has_golden = 1'b1;
      s.golden     = g;
      return s;
   endfunction

   // wide spread of operand values, weighted toward the edges
   function automatic logic [31:0] pick_operand();
      case ($urandom_range(0, 7))
         0:       return 32'h0000_0000;
         1:       return 32'hFFFF_FFFF;
         2:       return 32'h8000_0000;
         3:       return 32'h7FFF_FFFF;
         4:       return $urandom_range(0, 40);
         5:       return -$urandom_range(0, 40);
         default: return $urandom;
      endcase
   endfunction

   // sends one word: random gap, then hold start until busy is low at an edge
   task automatic send_word(stim_row_type s);
      int gap;
      gap = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 17) : 0;
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start            <= 1'b1;
      req_cmd          <= s.cmd;
      req_dest_value   <= s.dest_value;
      req_source_value <= s.source_value;
      do @(posedge clock); while (busy);
      // accepted at this edge; queue the expectation
      pending_results.push_back(s.has_golden ? s.golden : compute_alu(s.cmd, s.dest_value,
                                                                       s.source_value));
      op_seen[s.cmd]++;
      words_sent++;
   endtask

   // result checker: a strobe cycle ends at the rising edge
   always @(posedge clock) begin
      alu_out_type got;
      alu_out_type want;
      if (!reset && rsp_strobe) begin
         got = {rsp_result_value, rsp_write_back, rsp_flags_update, rsp_zero_flag,
                rsp_sign_flag, rsp_carry_flag, rsp_overflow_flag, rsp_divide_error};
         if (pending_results.size() == 0) begin
            $display("%0t: result word with nothing expected: %h", $time, got);
            error_count++;
         end else begin
            want = pending_results.pop_front();
            words_checked++;
            if (got.result_value !== want.result_value) begin
               $display("%0t: result_value exp %h got %h", $time, want.result_value,
                        got.result_value);
               error_count++;
            end
            if (got.write_back !== want.write_back) begin
               $display("%0t: write_back exp %b got %b", $time, want.write_back,
                        got.write_back);
               error_count++;
            end
            if (got.flags_update !== want.flags_update) begin
               $display("%0t: flags_update exp %b got %b", $time, want.flags_update,
                        got.flags_update);
               error_count++;
            end
            if (got.zero_flag !== want.zero_flag) begin
               $display("%0t: zero_flag exp %b got %b", $time, want.zero_flag, got.zero_flag);
               error_count++;
            end
            if (got.sign_flag !== want.sign_flag) begin
               $display("%0t: sign_flag exp %b got %b", $time, want.sign_flag, got.sign_flag);
               error_count++;
            end
            if (got.carry_flag !== want.carry_flag) begin
               $display("%0t: carry_flag exp %b got %b", $time, want.carry_flag,
                        got.carry_flag);
               error_count++;
            end
            if (got.overflow_flag !== want.overflow_flag) begin
               $display("%0t: overflow_flag exp %b got %b", $time, want.overflow_flag,
                        got.overflow_flag);
               error_count++;
            end
            if (got.divide_error !== want.divide_error) begin
               $display("%0t: divide_error exp %b got %b", $time, want.divide_error,
                        got.divide_error);
               error_count++;
            end
         end
      end
   end

   // watchdog: cycles with neither a word taken nor a result shown
   always @(posedge clock) begin
      if (reset || rsp_strobe || (start && !busy)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= WatchdogLimit) begin
            $display("%0t: watchdog, %0d results outstanding", $time, pending_results.size());
            $display("DONE: errors detected");
            $finish;
         end
      end
   end

   initial begin
      stim_row_type directed[$];
      stim_row_type row;
      int        drain;
      error_count      = 0;
      words_sent       = 0;
      words_checked    = 0;
      idle_cycles      = 0;
      foreach (op_seen[i]) op_seen[i] = 0;
      reset            = 1'b1;
      start            = 1'b0;
      req_cmd          = '0;
      req_dest_value   = '0;
      req_source_value = '0;

      // hand-typed rows: {result, wb, fu, z, s, c, v, derr}
      directed.push_back(mk_gold(aluf_pkg::CMD_ADD, 32'hFFFF_FFFF, 32'h0000_0001,
                                 {32'h0, 1'b1, 1'b1, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0}));
      directed.push_back(mk_gold(aluf_pkg::CMD_ADD, 32'h7FFF_FFFF, 32'h0000_0001,
                                 {32'h8000_0000, 1'b1, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0}));
      directed.push_back(mk_gold(aluf_pkg::CMD_ADD, 32'h0, 32'h0,
                                 {32'h0, 1'b1, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0}));
      directed.push_back(mk_gold(aluf_pkg::CMD_SUB, 32'h0, 32'h1,
                                 {32'hFFFF_FFFF, 1'b1, 1'b1, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0}));
      directed.push_back(mk_gold(aluf_pkg::CMD_SUB, 32'h8000_0000, 32'h1,
                                 {32'h7FFF_FFFF, 1'b1, 1'b1, 1'b0, 1'b0, 1'b1, 1'b1, 1'b0}));
      directed.push_back(mk_gold(aluf_pkg::CMD_CMP, 32'h5, 32'h5,
                                 {32'h0, 1'b0, 1'b1, 1'b1, 1'b0, 1'b1, 1'b0, 1'b0}));
      // mul with zero low half but nonzero high half: zero looks at all 64 bits
      directed.push_back(mk_gold(aluf_pkg::CMD_MUL, 32'h0001_0000, 32'h0001_0000,
                                 {32'h0, 1'b1, 1'b1, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0}));
      directed.push_back(mk_row(aluf_pkg::CMD_MUL, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
      // divide by zero, both kinds
      directed.push_back(mk_gold(aluf_pkg::CMD_UDIV, 32'hFFFF_FFFF, 32'h0,
                                 {32'h0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1}));
      directed.push_back(mk_gold(aluf_pkg::CMD_SDIV, 32'h8000_0000, 32'h0,
                                 {32'h0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1}));
      // most negative over minus one wraps to itself
      directed.push_back(mk_gold(aluf_pkg::CMD_SDIV, 32'h8000_0000, 32'hFFFF_FFFF,
                                 {32'h8000_0000, 1'b1, 1'b1, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0}));
      directed.push_back(mk_row(aluf_pkg::CMD_SDIV, -32'sd7, 32'd2));
      directed.push_back(mk_row(aluf_pkg::CMD_UDIV, 32'hFFFF_FFFF, 32'h3));
      directed.push_back(mk_row(aluf_pkg::CMD_AND, 32'hF0F0_F0F0, 32'hFFFF_0000));
      directed.push_back(mk_row(aluf_pkg::CMD_OR, 32'h0, 32'h8000_0001));
      directed.push_back(mk_row(aluf_pkg::CMD_XOR, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
      directed.push_back(mk_row(aluf_pkg::CMD_NOT, 32'h0, 32'h1234_5678));
      directed.push_back(mk_gold(aluf_pkg::CMD_TST, 32'hA, 32'h5,
                                 {32'h0, 1'b0, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0}));
      // shift count zero keeps the value and clears carry; count taken mod 32
      directed.push_back(mk_gold(aluf_pkg::CMD_SHL, 32'h8000_0001, 32'h20,
                                 {32'h8000_0001, 1'b1, 1'b1, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0}));
      directed.push_back(mk_gold(aluf_pkg::CMD_SHL, 32'h8000_0001, 32'h1,
                                 {32'h2, 1'b1, 1'b1, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0}));
      directed.push_back(mk_row(aluf_pkg::CMD_SHL, 32'hFFFF_FFFF, 32'h1F));
      directed.push_back(mk_gold(aluf_pkg::CMD_SHR, 32'h8000_0001, 32'h1,
                                 {32'h4000_0000, 1'b1, 1'b1, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0}));
      directed.push_back(mk_row(aluf_pkg::CMD_SHR, 32'h8000_0000, 32'hFFFF_FFFF));
      // unused codes give an all-zero word
      directed.push_back(mk_gold(4'd13, 32'hFFFF_FFFF, 32'hFFFF_FFFF, '0));
      directed.push_back(mk_gold(4'd15, 32'h1234_5678, 32'h1, '0));

      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed[i]) send_word(directed[i]);

      for (int i = 0; i < RandomWords; i++) begin
         row = mk_row(4'($urandom_range(0, 15)), pick_operand(), pick_operand());
         // most of the time a legal opcode; mod-32 and large counts for shifts
         if ($urandom_range(0, 9) != 0) row.cmd = 4'($urandom_range(0, 12));
         send_word(row);
      end
      start <= 1'b0;

      // wait out the pipeline, bounded by the watchdog
      while (pending_results.size() != 0) @(posedge clock);
      for (drain = 0; drain < DrainCycles; drain++) @(posedge clock);

      $display("sent %0d words, checked %0d results; add %0d mul %0d div %0d shifts %0d",
               words_sent, words_checked, op_seen[aluf_pkg::CMD_ADD],
               op_seen[aluf_pkg::CMD_MUL],
               op_seen[aluf_pkg::CMD_UDIV] + op_seen[aluf_pkg::CMD_SDIV],
               op_seen[aluf_pkg::CMD_SHL] + op_seen[aluf_pkg::CMD_SHR]);
      $display("unused-code words %0d", op_seen[13] + op_seen[14] + op_seen[15]);
      if (error_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
